/* rtl/tcp_client_connection_engine_top_defines.svh */
// assertion helpers used by the tcce_back module
`ifndef TCP_CLIENT_CONNECTION_ENGINE_TOP_DEFINES_SVH
`define TCP_CLIENT_CONNECTION_ENGINE_TOP_DEFINES_SVH

// property that holds at every clock edge out of reset
`define TCCE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// property that holds in the cycle after its trigger
`define TCCE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcce_pkg.sv */
`default_nettype none
package tcce_pkg;

    localparam int SUM_W = 21;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_RX_HDR  = 2'd0;
    localparam t_cmd CMD_RX_WORD = 2'd1;
    localparam t_cmd CMD_TX_REQ  = 2'd2;
    localparam t_cmd CMD_TX_WORD = 2'd3;

    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_LOCAL_ADDR  = 3'd0;
    localparam t_cfg_idx CFG_REMOTE_ADDR = 3'd1;
    localparam t_cfg_idx CFG_LOCAL_PORT  = 3'd2;
    localparam t_cfg_idx CFG_REMOTE_PORT = 3'd3;
    localparam t_cfg_idx CFG_INIT_SEQ    = 3'd4;
    localparam t_cfg_idx CFG_INIT_ACK    = 3'd5;

    typedef logic [1:0] t_status;
    localparam t_status STAT_OK       = 2'd0;
    localparam t_status STAT_CSUM_ERR = 2'd1;
    localparam t_status STAT_ACK_ERR  = 2'd2;
    localparam t_status STAT_NO_TRANS = 2'd3;

    localparam logic [7:0]  FLAG_MASK   = 8'h3f;
    localparam logic [7:0]  F_SYN       = 8'h02;
    localparam logic [7:0]  F_ACK       = 8'h10;
    localparam logic [7:0]  F_SYN_ACK   = 8'h12;
    localparam logic [7:0]  F_FIN_ACK   = 8'h11;
    localparam logic [7:0]  OFFSET_BYTE = 8'h50;
    localparam logic [15:0] HDR_LEN     = 16'd20;
    localparam logic [15:0] ALL_ONES    = 16'hffff;
    localparam logic [15:0] TX_WINDOW   = 16'd1;
    localparam logic [15:0] PROTO_TCP   = 16'd6;
    localparam logic [15:0] RST_LPORT   = 16'd2007;
    localparam logic [15:0] RST_RPORT   = 16'd2006;
    localparam logic [31:0] RST_ISEQ    = 32'd1;
    localparam logic [31:0] RST_IACK    = 32'd1;

    typedef enum logic [5:0] {
        CONN_CLOSED      = 6'b000001,
        CONN_SYN_SENT    = 6'b000010,
        CONN_ESTABLISHED = 6'b000100,
        CONN_FIN_WAIT1   = 6'b001000,
        CONN_FIN_WAIT2   = 6'b010000,
        CONN_TIME_WAIT   = 6'b100000
    } t_conn;

    typedef enum logic [2:0] {
        SEG_IDLE = 3'b001,
        SEG_RECV = 3'b010,
        SEG_SEND = 3'b100
    } t_seg;

    typedef enum logic [1:0] {
        DESC_NONE = 2'd0,
        DESC_ACK  = 2'd1,
        DESC_SEND = 2'd2
    } t_desc_kind;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] segment_length;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
        logic [7:0]  flag_bits;
        logic [3:0]  header_words;
        logic [15:0] window_size;
        logic [15:0] urgent_pointer;
        logic [15:0] checksum_field;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [15:0] payload_word;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status_code;
        logic        send_valid;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic [7:0]  out_flags;
        logic [15:0] out_checksum;
        logic [15:0] out_length;
        logic [2:0]  conn_state;
    } t_out_item;

    typedef struct packed {
        t_cmd             cmd;
        logic [SUM_W-1:0] sum;
        logic [15:0]      word;
        logic [15:0]      remaining;
        logic [31:0]      ack;
        logic [31:0]      seq_p1;
        logic [31:0]      seq_pd;
        logic [7:0]       flags;
        logic [15:0]      csum;
        logic [15:0]      length;
    } t_entry;

    typedef struct packed {
        logic        load_seq;
        logic        load_ack;
        logic [31:0] value;
    } t_cfg_upd;

    typedef struct packed {
        t_desc_kind  kind;
        t_status     status;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [7:0]  flags;
        logic [15:0] csum;
        logic [15:0] length;
        logic [2:0]  conn;
    } t_desc;

    function automatic logic [15:0] fold_sum(input logic [SUM_W-1:0] x);
        logic [16:0] a;
        a = {1'b0, x[15:0]} + 17'(x[SUM_W-1:16]);
        return a[15:0] + 16'(a[16]);
    endfunction

    function automatic logic [SUM_W-1:0] half_sum(input logic [31:0] v);
        return SUM_W'(v[31:16]) + SUM_W'(v[15:0]);
    endfunction

    function automatic logic [2:0] conn_code(input t_conn c);
        logic [2:0] r;
        unique case (c)
            CONN_CLOSED:      r = 3'd0;
            CONN_SYN_SENT:    r = 3'd1;
            CONN_ESTABLISHED: r = 3'd2;
            CONN_FIN_WAIT1:   r = 3'd3;
            CONN_FIN_WAIT2:   r = 3'd4;
            CONN_TIME_WAIT:   r = 3'd5;
            default:          r = 3'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* rtl/tcce_front.sv */
`default_nettype none
module tcce_front (
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire tcce_pkg::t_in_item       i_in_data,
    input  wire logic [tcce_pkg::SUM_W-1:0] i_pseudo,
    input  wire logic [tcce_pkg::SUM_W-1:0] i_tx_const,
    input  wire logic                     i_full,
    output logic                          o_push,
    output tcce_pkg::t_entry              o_entry
);
    import tcce_pkg::*;

    logic [15:0] tx_len;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;
    assign tx_len     = i_in_data.segment_length + HDR_LEN;

    always_comb begin
        o_entry        = '0;
        o_entry.cmd    = i_in_data.command;
        o_entry.word   = i_in_data.payload_word;
        o_entry.ack    = i_in_data.ack_number;
        o_entry.flags  = i_in_data.flag_bits;
        o_entry.csum   = i_in_data.checksum_field;
        o_entry.length = i_in_data.segment_length;
        o_entry.seq_p1 = i_in_data.seq_number + 32'd1;
        o_entry.seq_pd = i_in_data.seq_number
                       + (32'(i_in_data.segment_length) - 32'({i_in_data.header_words, 2'b00}));
        unique case (i_in_data.command)
            CMD_RX_HDR: begin
                o_entry.sum = i_pseudo
                            + SUM_W'(i_in_data.segment_length)
                            + SUM_W'(i_in_data.source_port)
                            + SUM_W'(i_in_data.dest_port)
                            + half_sum(i_in_data.seq_number)
                            + half_sum(i_in_data.ack_number)
                            + SUM_W'({i_in_data.header_words, 4'b0000, i_in_data.flag_bits})
                            + SUM_W'(i_in_data.window_size)
                            + SUM_W'(i_in_data.urgent_pointer);
                o_entry.remaining = (i_in_data.segment_length > HDR_LEN)
                                  ? i_in_data.segment_length - HDR_LEN : '0;
            end
            CMD_TX_REQ: begin
                o_entry.sum = i_tx_const + SUM_W'(tx_len) + SUM_W'(i_in_data.flag_bits);
                o_entry.remaining = i_in_data.segment_length;
            end
            default: begin
                o_entry.sum       = '0;
                o_entry.remaining = '0;
            end
        endcase
    end
endmodule
`default_nettype wire

/* rtl/tcce_fifo.sv */
`default_nettype none
module tcce_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire tcce_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output logic                  o_full,
    output logic                  o_empty,
    output tcce_pkg::t_entry      o_entry
);
    import tcce_pkg::*;

    t_entry     r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= !r_wr;
            if (i_pop)  r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/tcce_back.sv */
`default_nettype none
`include "tcp_client_connection_engine_top_defines.svh"
module tcce_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_empty,
    input  wire tcce_pkg::t_entry   i_entry,
    output logic                    o_pop,
    input  wire tcce_pkg::t_cfg_upd i_cfg,
    input  wire logic               i_desc_ready,
    output logic                    o_desc_valid,
    output tcce_pkg::t_desc         o_desc
);
    import tcce_pkg::*;

    t_conn       r_conn, n_conn;
    t_seg        r_seg, n_seg;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_ack, n_ack;
    logic [31:0] r_exp, n_exp;
    logic [15:0] r_acc, n_acc;
    logic [15:0] r_br, n_br;
    logic [31:0] r_h_ack, n_h_ack;
    logic [31:0] r_h_seq_p1, n_h_seq_p1;
    logic [31:0] r_h_seq_pd, n_h_seq_pd;
    logic [7:0]  r_h_flags, n_h_flags;
    logic [15:0] r_h_csum, n_h_csum;
    logic [15:0] r_h_len, n_h_len;
    logic        r_desc_v;
    t_desc       r_desc, n_desc;

    logic        rx_done, tx_done;
    logic [15:0] masked, br_after, acc_after;
    logic [7:0]  f;
    t_conn       c;

    assign o_pop        = !i_empty && (!r_desc_v || i_desc_ready);
    assign o_desc_valid = r_desc_v;
    assign o_desc       = r_desc;

    // odd tail keeps only the high byte
    assign masked    = (r_br == 16'd1) ? {i_entry.word[15:8], 8'h00} : i_entry.word;
    assign br_after  = (r_br == 16'd1) ? '0 : r_br - 16'd2;
    assign acc_after = fold_sum(SUM_W'(r_acc) + SUM_W'(masked));

    always_comb begin
        n_conn = r_conn; n_seg = r_seg; n_seq = r_seq; n_ack = r_ack; n_exp = r_exp;
        n_acc = r_acc; n_br = r_br;
        n_h_ack = r_h_ack; n_h_seq_p1 = r_h_seq_p1; n_h_seq_pd = r_h_seq_pd;
        n_h_flags = r_h_flags; n_h_csum = r_h_csum; n_h_len = r_h_len;
        n_desc = '0;
        rx_done = 1'b0;
        tx_done = 1'b0;
        f = '0;
        c = r_conn;
        if (o_pop) begin
            unique case (i_entry.cmd)
                CMD_RX_HDR: begin
                    n_h_ack    = i_entry.ack;
                    n_h_seq_p1 = i_entry.seq_p1;
                    n_h_seq_pd = i_entry.seq_pd;
                    n_h_flags  = i_entry.flags;
                    n_h_csum   = i_entry.csum;
                    n_h_len    = i_entry.length;
                    n_acc      = fold_sum(i_entry.sum);
                    n_br       = i_entry.remaining;
                    n_seg      = SEG_RECV;
                    rx_done    = (i_entry.remaining == '0);
                end
                CMD_RX_WORD: begin
                    if (r_seg == SEG_RECV) begin
                        n_acc   = acc_after;
                        n_br    = br_after;
                        rx_done = (br_after == '0);
                    end
                end
                CMD_TX_REQ: begin
                    n_h_flags = i_entry.flags;
                    n_h_len   = i_entry.length;
                    n_acc     = fold_sum(i_entry.sum + half_sum(r_seq) + half_sum(r_ack));
                    n_br      = i_entry.remaining;
                    n_seg     = SEG_SEND;
                    tx_done   = (i_entry.remaining == '0);
                end
                CMD_TX_WORD: begin
                    if (r_seg == SEG_SEND) begin
                        n_acc   = acc_after;
                        n_br    = br_after;
                        tx_done = (br_after == '0);
                    end
                end
                default: begin
                end
            endcase
        end

        if (rx_done) begin
            n_seg = SEG_IDLE;
            f = n_h_flags & FLAG_MASK;
            n_desc.kind = DESC_NONE;
            priority if ((~n_acc) != n_h_csum) begin
                n_desc.status = STAT_CSUM_ERR;
            end else if (n_h_ack != r_exp) begin
                n_desc.status = STAT_ACK_ERR;
            end else if (r_conn == CONN_SYN_SENT && f == F_SYN_ACK) begin
                n_conn = CONN_ESTABLISHED;
                n_seq  = n_h_ack;
                n_ack  = n_h_seq_p1;
                n_desc.kind = DESC_ACK;
            end else if (r_conn == CONN_ESTABLISHED) begin
                n_seq  = n_h_ack;
                n_ack  = n_h_seq_pd;
                n_desc.kind = DESC_ACK;
            end else if (r_conn == CONN_FIN_WAIT1 && f == F_ACK) begin
                n_conn = CONN_FIN_WAIT2;
                n_seq  = n_h_ack;
                n_ack  = n_h_seq_p1;
                n_desc.status = STAT_OK;
            end else if (r_conn == CONN_FIN_WAIT2 && f == F_FIN_ACK) begin
                n_conn = CONN_TIME_WAIT;
                n_desc.kind = DESC_ACK;
            end else begin
                n_desc.status = STAT_NO_TRANS;
            end
            if (n_desc.kind == DESC_ACK) begin
                n_desc.status = STAT_OK;
                n_desc.seq    = n_seq;
                n_desc.ack    = n_ack;
                n_exp = (n_conn == CONN_ESTABLISHED) ? n_seq : n_seq + 32'd1;
            end
        end

        if (tx_done) begin
            n_seg = SEG_IDLE;
            f = n_h_flags & FLAG_MASK;
            if (c == CONN_CLOSED && f == F_SYN) c = CONN_SYN_SENT;
            if (c == CONN_ESTABLISHED && f == F_FIN_ACK) c = CONN_FIN_WAIT1;
            n_conn = c;
            n_exp  = (c == CONN_ESTABLISHED) ? r_seq + 32'(n_h_len) : r_seq + 32'd1;
            n_desc.kind   = DESC_SEND;
            n_desc.status = STAT_OK;
            n_desc.seq    = r_seq;
            n_desc.ack    = r_ack;
            n_desc.flags  = n_h_flags;
            n_desc.csum   = ~n_acc;
            n_desc.length = n_h_len + HDR_LEN;
        end
        n_desc.conn = conn_code(n_conn);

        if (i_cfg.load_seq) n_seq = i_cfg.value;
        if (i_cfg.load_ack) n_ack = i_cfg.value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn   <= CONN_CLOSED;
            r_seg    <= SEG_IDLE;
            r_seq    <= RST_ISEQ;
            r_ack    <= RST_IACK;
            r_exp    <= '0;
            r_acc    <= '0;
            r_br     <= '0;
            r_desc_v <= 1'b0;
        end else begin
            r_conn <= n_conn;
            r_seg  <= n_seg;
            r_seq  <= n_seq;
            r_ack  <= n_ack;
            r_exp  <= n_exp;
            r_acc  <= n_acc;
            r_br   <= n_br;
            if (o_pop) begin
                r_desc_v <= rx_done || tx_done;
            end else if (i_desc_ready) begin
                r_desc_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_ack    <= n_h_ack;
        r_h_seq_p1 <= n_h_seq_p1;
        r_h_seq_pd <= n_h_seq_pd;
        r_h_flags  <= n_h_flags;
        r_h_csum   <= n_h_csum;
        r_h_len    <= n_h_len;
        if (o_pop) r_desc <= n_desc;
    end

    `TCCE_ASSERT(a_idle_no_bytes, (r_seg == SEG_IDLE) == (r_br == 16'd0), "segment idle but bytes pending")
    `TCCE_ASSERT_NEXT(a_state_hold, !o_pop && !i_cfg.load_seq && !i_cfg.load_ack, $stable(r_conn) && $stable(r_seq) && $stable(r_ack), "connection state moved with no word")
    `TCCE_ASSERT_NEXT(a_desc_hold, r_desc_v && !i_desc_ready, r_desc_v && $stable(r_desc), "pending result lost")
    `TCCE_ASSERT_NEXT(a_fw2_entry, r_conn != CONN_FIN_WAIT1 && r_conn != CONN_FIN_WAIT2, r_conn != CONN_FIN_WAIT2, "fin_wait2 entered out of order")
endmodule
`default_nettype wire

/* rtl/tcce_emit.sv */
`default_nettype none
module tcce_emit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_desc_valid,
    input  wire tcce_pkg::t_desc            i_desc,
    output logic                            o_desc_ready,
    input  wire logic [tcce_pkg::SUM_W-1:0] i_ack_const,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output tcce_pkg::t_out_item             o_out_data
);
    import tcce_pkg::*;

    logic      r_out_v;
    t_out_item r_out, n_out;
    logic      take;

    assign o_desc_ready = !r_out_v || i_out_ready;
    assign take         = i_desc_valid && o_desc_ready;
    assign o_out_valid  = r_out_v;
    assign o_out_data   = r_out;

    always_comb begin
        n_out             = '0;
        n_out.status_code = i_desc.status;
        n_out.conn_state  = i_desc.conn;
        unique case (i_desc.kind)
            DESC_ACK: begin
                n_out.send_valid   = 1'b1;
                n_out.out_seq      = i_desc.seq;
                n_out.out_ack      = i_desc.ack;
                n_out.out_flags    = F_ACK;
                n_out.out_checksum = ~fold_sum(i_ack_const + half_sum(i_desc.seq)
                                               + half_sum(i_desc.ack));
                n_out.out_length   = HDR_LEN;
            end
            DESC_SEND: begin
                n_out.send_valid   = 1'b1;
                n_out.out_seq      = i_desc.seq;
                n_out.out_ack      = i_desc.ack;
                n_out.out_flags    = i_desc.flags;
                n_out.out_checksum = i_desc.csum;
                n_out.out_length   = i_desc.length;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (take) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) r_out <= n_out;
    end
endmodule
`default_nettype wire

/* rtl/tcp_client_connection_engine_top.sv */
// single-connection tcp client engine
// input channel (i_in_valid/o_in_ready/i_in_data): one word per cycle while ready.
// a segment starts with a receive header or a send request word, followed by its
// 16-bit payload words. a result word leaves on o_out_valid/i_out_ready/o_out_data
// when a segment completes: receive status, state step and optional ack header, or
// the header and checksum of a send.
// config channel (i_cfg_valid/o_cfg_ready/i_cfg_index/i_cfg_data) is always ready;
// write it only while no segment is in flight.
// throughput: one input word per cycle, sustained while the output is not stalled.
// the accepted word that completes a segment reaches the output in order through:
// classify into a 2-entry queue, state update in the back end, checksum and
// output register.
// a stalled receiver holds the output register; once the back end holds a pending
// result as well, the queue fills and o_in_ready drops.
// reset (synchronous, active low) restores the control registers, not the data
// registers, to defaults: state closed, sequence and acknowledgement numbers 1.
`default_nettype none
module tcp_client_connection_engine_top (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire tcce_pkg::t_in_item    i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output tcce_pkg::t_out_item        o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire tcce_pkg::t_cfg_idx    i_cfg_index,
    input  wire logic [31:0]           i_cfg_data
);
    import tcce_pkg::*;

    localparam logic [SUM_W-1:0] RST_PSEUDO = SUM_W'(PROTO_TCP);
    localparam logic [SUM_W-1:0] RST_TX_CONST = RST_PSEUDO + SUM_W'(RST_LPORT)
        + SUM_W'(RST_RPORT) + SUM_W'({OFFSET_BYTE, 8'h00}) + SUM_W'(TX_WINDOW);
    localparam logic [SUM_W-1:0] RST_ACK_CONST = RST_PSEUDO + SUM_W'(HDR_LEN)
        + SUM_W'(RST_LPORT) + SUM_W'(RST_RPORT) + SUM_W'({OFFSET_BYTE, F_ACK})
        + SUM_W'(TX_WINDOW);

    logic [31:0]      r_laddr, n_laddr;
    logic [31:0]      r_raddr, n_raddr;
    logic [15:0]      r_lport, n_lport;
    logic [15:0]      r_rport, n_rport;
    logic [SUM_W-1:0] r_pseudo, n_pseudo;
    logic [SUM_W-1:0] r_tx_const, n_tx_const;
    logic [SUM_W-1:0] r_ack_const, n_ack_const;
    logic             cfg_wr;
    t_cfg_upd         cfg_upd;

    logic   push, pop, full, empty;
    t_entry f_entry, q_entry;
    logic   desc_valid, desc_ready;
    t_desc  desc;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid;

    always_comb begin
        n_laddr = r_laddr;
        n_raddr = r_raddr;
        n_lport = r_lport;
        n_rport = r_rport;
        cfg_upd = '0;
        cfg_upd.value = i_cfg_data;
        if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_LOCAL_ADDR:  n_laddr = i_cfg_data;
                CFG_REMOTE_ADDR: n_raddr = i_cfg_data;
                CFG_LOCAL_PORT:  n_lport = i_cfg_data[15:0];
                CFG_REMOTE_PORT: n_rport = i_cfg_data[15:0];
                CFG_INIT_SEQ:    cfg_upd.load_seq = 1'b1;
                CFG_INIT_ACK:    cfg_upd.load_ack = 1'b1;
                default: begin
                end
            endcase
        end
        // pseudo-header and fixed outgoing header words, kept pre-summed
        n_pseudo    = half_sum(n_laddr) + half_sum(n_raddr) + SUM_W'(PROTO_TCP);
        n_tx_const  = n_pseudo + SUM_W'(n_lport) + SUM_W'(n_rport)
                    + SUM_W'({OFFSET_BYTE, 8'h00}) + SUM_W'(TX_WINDOW);
        n_ack_const = n_pseudo + SUM_W'(HDR_LEN) + SUM_W'(n_lport) + SUM_W'(n_rport)
                    + SUM_W'({OFFSET_BYTE, F_ACK}) + SUM_W'(TX_WINDOW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_laddr     <= '0;
            r_raddr     <= '0;
            r_lport     <= RST_LPORT;
            r_rport     <= RST_RPORT;
            r_pseudo    <= RST_PSEUDO;
            r_tx_const  <= RST_TX_CONST;
            r_ack_const <= RST_ACK_CONST;
        end else begin
            r_laddr     <= n_laddr;
            r_raddr     <= n_raddr;
            r_lport     <= n_lport;
            r_rport     <= n_rport;
            r_pseudo    <= n_pseudo;
            r_tx_const  <= n_tx_const;
            r_ack_const <= n_ack_const;
        end
    end

    tcce_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_pseudo   (r_pseudo),
        .i_tx_const (r_tx_const),
        .i_full     (full),
        .o_push     (push),
        .o_entry    (f_entry)
    );

    tcce_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_entry (q_entry)
    );

    tcce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_entry      (q_entry),
        .o_pop        (pop),
        .i_cfg        (cfg_upd),
        .i_desc_ready (desc_ready),
        .o_desc_valid (desc_valid),
        .o_desc       (desc)
    );

    tcce_emit u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (desc_valid),
        .i_desc       (desc),
        .o_desc_ready (desc_ready),
        .i_ack_const  (r_ack_const),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );
endmodule
`default_nettype wire
